FILE: rtl/core/bdq_pkg.sv
// Shared types and constants for the bounded deque.
// No dependencies; every other file in rtl/core depends on this package.
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(16);
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -DATA_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

FILE: rtl/core/bdq_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on bdq_pkg for field widths and the status type.
interface bdq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bdq_pkg::CMD_W-1:0]            cmd;
  logic signed [bdq_pkg::DATA_W-1:0]    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bdq_pkg::DATA_W-1:0]    data_out;
  bdq_pkg::status_t                     status;
  logic                                 now_empty;
  logic                                 now_full;

  modport source (output valid, output data_out, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input data_out, input status, input now_empty,
                  input now_full, output ready);
endinterface

FILE: rtl/core/bdq_mem.sv
// Circular word store: one write port, one read port, registered read data.
// Depends on bdq_pkg for the word width.
module bdq_mem #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic signed [bdq_pkg::DATA_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic signed [bdq_pkg::DATA_W-1:0] rd_data
);
  import bdq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/bounded_deque.sv
// Bounded double-ended queue of signed 32-bit words: top level.
// Depends on bdq_pkg, the channel interfaces in bdq_if.sv and bdq_mem.
//
// The block holds up to min(capacity, DEPTH) words in a circular store
// addressed by a head index (front word), a tail index (slot past the rear
// word) and a count. One command word is taken at a time and gives exactly
// one result word with the popped or peeked data (-1 when empty, 0 for
// pushes and unused codes), a status and the empty/full flags after the
// command. Pushes, refused pushes, commands on an empty queue and unused
// codes go straight to the output register; a pop or peek of a live word
// first reads the store's registered port. A result waiting in the output
// register does not block the next command if it is taken in the same
// cycle. Capacity is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, as the block does not enforce it. It resets
// to 16; a value above DEPTH acts as DEPTH, and lowering it below the count
// keeps the words but refuses pushes. Store contents have no reset and need
// no clearing pass: only slots holding live words are ever read.
module bounded_deque #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bdq_in_if.sink                     in_ch,
  bdq_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]  cfg_wdata
);
  import bdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [LIM_W-1:0] DEPTH_L  = LIM_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CAP_W-1:0]          cap_r;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [IDX_W-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]  out_data_r, out_data_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic                      out_full_r, out_full_nxt;
  logic                      pend_empty_r, pend_empty_nxt;
  logic                      pend_full_r, pend_full_nxt;

  logic                      accept;
  cmd_t                      cmd;
  logic [LIM_W-1:0]          cap_l, lim;
  logic                      full_now, empty_now;
  logic [IDX_W-1:0]          head_prev, head_next, tail_prev, tail_next;

  logic                      wr_en, rd_en;
  logic [IDX_W-1:0]          wr_addr, rd_addr;
  logic signed [DATA_W-1:0]  rd_data;

  // Take a command only between reads, and only when the output register
  // is free or being drained this cycle.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);

  // Effective capacity is min(capacity, DEPTH).
  assign cap_l     = LIM_W'(cap_r);
  assign lim       = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
  assign full_now  = LIM_W'(count_r) >= lim;
  assign empty_now = (count_r == '0);

  // Wrap the indices around the ring.
  assign head_prev = (head_r == '0) ? IDX_LAST : head_r - IDX_W'(1);
  assign head_next = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
  assign tail_prev = (tail_r == '0) ? IDX_LAST : tail_r - IDX_W'(1);
  assign tail_next = (tail_r == IDX_LAST) ? '0 : tail_r + IDX_W'(1);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    pend_empty_nxt = pend_empty_r;
    pend_full_nxt  = pend_full_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Default result: done, zero data; flags are patched below.
          out_data_nxt   = '0;
          out_status_nxt = ST_DONE;
          out_valid_nxt  = 1'b1;
          priority case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              if (full_now) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (cmd == CMD_PUSH_FRONT) begin
                  wr_addr  = head_prev;
                  head_nxt = head_prev;
                end else begin
                  wr_addr  = tail_r;
                  tail_nxt = tail_next;
                end
              end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT, CMD_POP_REAR, CMD_PEEK_REAR: begin
              if (empty_now) begin
                out_data_nxt   = EMPTY_WORD;
                out_status_nxt = ST_EMPTY;
              end else begin
                // Issue the read and park the result until data returns.
                rd_en         = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
                  rd_addr = head_r;
                end else begin
                  rd_addr = tail_prev;
                end
                if (cmd == CMD_POP_FRONT) begin
                  head_nxt  = head_next;
                  count_nxt = count_r - CNT_W'(1);
                end else if (cmd == CMD_POP_REAR) begin
                  tail_nxt  = tail_prev;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            default: begin
              // Unused codes change nothing.
            end
          endcase
          out_empty_nxt  = (count_nxt == '0);
          out_full_nxt   = LIM_W'(count_nxt) >= lim;
          pend_empty_nxt = out_empty_nxt;
          pend_full_nxt  = out_full_nxt;
        end
      end
      S_READ: begin
        // Output register is free here: it was empty or drained at accept.
        out_valid_nxt  = 1'b1;
        out_data_nxt   = rd_data;
        out_status_nxt = ST_DONE;
        out_empty_nxt  = pend_empty_r;
        out_full_nxt   = pend_full_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    pend_empty_r <= pend_empty_nxt;
    pend_full_r  <= pend_full_nxt;
  end

  // A write and a read never land on the same edge: a push writes at its
  // own accept, and a later pop reads at a later accept.
  bdq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.now_empty = out_empty_r;
  assign out_ch.now_full  = out_full_r;

endmodule
